>>> src/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// shared types and sizes for the priority ready-queue select block
// ----------------------------------------------------------------------------
`default_nettype none

package prqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  proc_id;
    logic [7:0]  priority_req;
    logic [15:0] prog_counter;
    logic [15:0] code_size;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  chosen_id;
    logic [15:0] chosen_pc;
    logic        queue_full;
    logic [4:0]  entry_count;
  } rsp_t;

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic [7:0]        id;
    logic [7:0]        prio;
    logic [15:0]       pc;
    logic [15:0]       size;
    logic [SLOT_W-1:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_DONE
  } eng_state_t;

endpackage

`default_nettype wire

>>> src/priority_ready_queue_select.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_select
// ready-queue table with add and highest-priority select
// ----------------------------------------------------------------------------
// One word at a time. An add steps through the valid bits to find the first
// free slot and writes the entry there; an add to a full table goes straight
// to the done state. A select walks the entry memory through its single read
// port, one entry a cycle, then decides; every finished entry removed on the
// way adds one more pass. The result is held in an output register, so a new
// word is taken while it waits; the engine only stalls in its done state while
// that register is still full and not being read.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_select (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire prqs_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output prqs_pkg::rsp_t      rsp
);

  import prqs_pkg::*;

  eng_status_t status;
  rsp_t        eng_rsp;
  logic        take;

  assign req_ready = status.idle;
  assign take      = !rsp_valid || rsp_ready;

  prqs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (req_valid && req_ready),
    .req    (req),
    .take   (take),
    .status (status),
    .rsp    (eng_rsp)
  );

  // output register parts the engine from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.done) begin
      rsp_valid <= 1'b1;
      rsp       <= eng_rsp;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/prqs_ram.sv
// ----------------------------------------------------------------------------
// prqs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module prqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/prqs_engine.sv
// ----------------------------------------------------------------------------
// prqs_engine
// sequencer that adds entries and scans the entry memory for the best one
// ----------------------------------------------------------------------------
`default_nettype none

module prqs_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire prqs_pkg::req_t       req,
  input  wire logic                 take,
  output prqs_pkg::eng_status_t     status,
  output prqs_pkg::rsp_t            rsp
);

  import prqs_pkg::*;

  eng_state_t state, state_next;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [COUNT_W-1:0]     count;
  req_t                   req_q;

  logic [SLOT_W-1:0] srch_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic              chk_v;
  logic [SLOT_W-1:0] chk_idx;

  logic              have_best;
  logic [SLOT_W-1:0] best_slot;
  logic [7:0]        best_id;
  logic [7:0]        best_prio;
  logic [15:0]       best_pc;
  logic [15:0]       best_size;
  logic [SLOT_W-1:0] best_ord;

  // removal of the previous pass, applied to ranks during this pass
  logic              pend;
  logic [SLOT_W-1:0] pend_rank;

  logic              res_found;
  logic [7:0]        res_id;
  logic [15:0]       res_pc;
  logic              res_full;

  // memory ports
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  entry_t            mem_rdata;

  logic              slot_live;
  logic              ord_shift;
  logic [SLOT_W-1:0] ord_adj;
  logic              better;
  logic              add_wr;
  logic              is_full;
  logic              last_rd;
  logic              finished;

  prqs_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  always_comb begin
    is_full   = count >= COUNT_W'(QUEUE_DEPTH);
    last_rd   = rd_idx == SLOT_W'(QUEUE_DEPTH - 1);
    finished  = best_pc == best_size;
    slot_live = chk_v && valid[chk_idx];
    ord_shift = slot_live && pend && (mem_rdata.order > pend_rank);
    ord_adj   = ord_shift ? mem_rdata.order - SLOT_W'(1) : mem_rdata.order;
    better    = slot_live &&
                (!have_best || (mem_rdata.prio > best_prio) ||
                 ((mem_rdata.prio == best_prio) && (ord_adj < best_ord)));
    add_wr    = (state == ST_ADD) && !valid[srch_idx];

    mem_re    = state == ST_SCAN;
    mem_we    = add_wr || ord_shift;
    if (add_wr) begin
      mem_waddr       = srch_idx;
      mem_wdata.id    = req_q.proc_id;
      mem_wdata.prio  = req_q.priority_req;
      mem_wdata.pc    = req_q.prog_counter;
      mem_wdata.size  = req_q.code_size;
      mem_wdata.order = count[SLOT_W-1:0];
    end else begin
      // rank write-back of a younger entry after a removal
      mem_waddr       = chk_idx;
      mem_wdata       = mem_rdata;
      mem_wdata.order = ord_adj;
    end
  end

  always_comb begin
    state_next  = state;
    status.idle = 1'b0;
    status.done = 1'b0;
    case (state)
      ST_IDLE: begin
        status.idle = 1'b1;
        if (start) begin
          if (req.req_type == REQ_SELECT) begin
            state_next = ST_SCAN;
          end else if (is_full) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (add_wr) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (have_best && finished) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        status.done = take;
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      chk_v <= 1'b0;
      pend  <= 1'b0;
    end else begin
      chk_v   <= state == ST_SCAN;
      chk_idx <= rd_idx;

      if (better) begin
        have_best <= 1'b1;
        best_slot <= chk_idx;
        best_id   <= mem_rdata.id;
        best_prio <= mem_rdata.prio;
        best_pc   <= mem_rdata.pc;
        best_size <= mem_rdata.size;
        best_ord  <= ord_adj;
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            req_q     <= req;
            srch_idx  <= '0;
            rd_idx    <= '0;
            have_best <= 1'b0;
            pend      <= 1'b0;
            res_found <= 1'b0;
            res_id    <= '0;
            res_pc    <= '0;
            res_full  <= (req.req_type == REQ_ADD) && is_full;
          end
        end
        ST_ADD: begin
          if (add_wr) begin
            valid[srch_idx] <= 1'b1;
            count           <= count + COUNT_W'(1);
          end else begin
            srch_idx <= srch_idx + SLOT_W'(1);
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + SLOT_W'(1);
        end
        ST_DECIDE: begin
          rd_idx    <= '0;
          have_best <= 1'b0;
          if (have_best && finished) begin
            // drop the finished entry and rescan with ranks closing up
            valid[best_slot] <= 1'b0;
            count            <= count - COUNT_W'(1);
            pend             <= 1'b1;
            pend_rank        <= best_ord;
          end else begin
            pend      <= 1'b0;
            res_found <= have_best;
            res_id    <= have_best ? best_id : 8'd0;
            res_pc    <= have_best ? best_pc : 16'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp.found       = res_found;
    rsp.chosen_id   = res_id;
    rsp.chosen_pc   = res_pc;
    rsp.queue_full  = res_full;
    rsp.entry_count = 5'(count);
  end

endmodule

`default_nettype wire

>>> test/prqs_checker.sv
// ----------------------------------------------------------------------------
// prqs_checker
// watches both channels, predicts each select and add, compares responses
// ----------------------------------------------------------------------------
// Keeps its own copy of the ready-queue table. Every accepted request word is
// applied to that copy at once and the response it should produce is queued.
// Every accepted response word is compared field by field with the oldest
// queued response.
// ----------------------------------------------------------------------------
`default_nettype none

module prqs_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire prqs_pkg::req_t req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire prqs_pkg::rsp_t rsp,
  output int                  fail_count,
  output int                  pending
);

  import prqs_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;

  logic        tbl_live [DEPTH];
  logic [7:0]  tbl_id   [DEPTH];
  logic [7:0]  tbl_prio [DEPTH];
  logic [15:0] tbl_pc   [DEPTH];
  logic [15:0] tbl_size [DEPTH];
  int unsigned tbl_rank [DEPTH];
  int unsigned live_count;

  rsp_t expected_rsp[$];

  // applies one request word to the table copy and returns its response
  function automatic rsp_t next_schedule_result(input req_t w);
    rsp_t        r;
    int          slot;
    int          best;
    int          tries;
    int unsigned gone_rank;
    r = '0;
    if (w.req_type == REQ_ADD) begin
      if (live_count >= DEPTH) begin
        r.queue_full = 1'b1;
      end else begin
        slot = DEPTH;
        for (int s = DEPTH - 1; s >= 0; s--) begin
          if (!tbl_live[s]) slot = s;
        end
        if (slot < DEPTH) begin
          tbl_live[slot] = 1'b1;
          tbl_id[slot]   = w.proc_id;
          tbl_prio[slot] = w.priority_req;
          tbl_pc[slot]   = w.prog_counter;
          tbl_size[slot] = w.code_size;
          tbl_rank[slot] = live_count;
          live_count++;
        end else begin
          r.queue_full = 1'b1;
        end
      end
    end else begin
      for (tries = 0; tries <= DEPTH; tries++) begin
        best = DEPTH;
        for (int s = 0; s < DEPTH; s++) begin
          if (tbl_live[s] && (best == DEPTH || tbl_prio[s] > tbl_prio[best] ||
              (tbl_prio[s] == tbl_prio[best] && tbl_rank[s] < tbl_rank[best])))
            best = s;
        end
        if (best >= DEPTH) break;
        if (tbl_pc[best] == tbl_size[best]) begin
          // finished entry leaves for good, younger ranks close up
          gone_rank      = tbl_rank[best];
          tbl_live[best] = 1'b0;
          for (int s = 0; s < DEPTH; s++) begin
            if (tbl_live[s] && tbl_rank[s] > gone_rank) tbl_rank[s]--;
          end
          if (live_count > 0) live_count--;
          continue;
        end
        r.found     = 1'b1;
        r.chosen_id = tbl_id[best];
        r.chosen_pc = tbl_pc[best];
        break;
      end
    end
    r.entry_count = live_count[4:0];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int s = 0; s < DEPTH; s++) tbl_live[s] = 1'b0;
      live_count = 0;
      fail_count = 0;
      expected_rsp.delete();
    end else begin
      // response is checked first: a word taken at this edge cannot answer yet
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: response word mismatch, expected none, got %h", $time, rsp);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("found", 16'(want.found), 16'(rsp.found));
          check_field("chosen_id", 16'(want.chosen_id), 16'(rsp.chosen_id));
          check_field("chosen_pc", want.chosen_pc, rsp.chosen_pc);
          check_field("queue_full", 16'(want.queue_full), 16'(rsp.queue_full));
          check_field("entry_count", 16'(want.entry_count), 16'(rsp.entry_count));
        end
      end
      if (req_valid && req_ready) begin
        expected_rsp = {expected_rsp, next_schedule_result(req)};
      end
    end
    pending = expected_rsp.size();
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the priority ready-queue select block
// ----------------------------------------------------------------------------
// A short directed run covers the empty queue, ties, finished entries and a
// full table, then bursts of adds and selects run under three flow-control
// mixes. Long-lived entries are kept few and low in priority so the table
// keeps filling and draining. Checking lives in prqs_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import prqs_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int   fail_count;
  int   pending;

  int send_gap_pct;
  int stall_pct;
  int sticky_left;

  priority_ready_queue_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  prqs_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic req_t add_word(input logic [7:0] id, input logic [7:0] prio,
                                    input logic [15:0] pc, input logic [15:0] size);
    req_t w;
    w.req_type     = REQ_ADD;
    w.proc_id      = id;
    w.priority_req = prio;
    w.prog_counter = pc;
    w.code_size    = size;
    return w;
  endfunction

  // payload fields of a select are don't-care, so they carry noise
  function automatic req_t select_word();
    req_t w;
    w.req_type     = REQ_SELECT;
    w.proc_id      = 8'($urandom);
    w.priority_req = 8'($urandom);
    w.prog_counter = 16'($urandom);
    w.code_size    = 16'($urandom);
    return w;
  endfunction

  // mostly finished entries; a rare low-priority one that never leaves
  function automatic req_t random_add();
    req_t w;
    w = add_word(8'($urandom), 8'd0, 16'($urandom), 16'd0);
    if (sticky_left > 0 && $urandom_range(0, 99) == 0) begin
      sticky_left--;
      w.priority_req = 8'($urandom_range(0, 3));
      w.code_size    = w.prog_counter + 16'($urandom_range(1, 65535));
    end else begin
      case ($urandom_range(0, 5))
        0:       w.priority_req = 8'd4;
        1:       w.priority_req = 8'd5;
        2:       w.priority_req = 8'h80;
        3:       w.priority_req = 8'hff;
        default: w.priority_req = 8'($urandom_range(4, 255));
      endcase
      w.code_size = w.prog_counter;
    end
    return w;
  endfunction

  // called and returns on a falling edge
  task automatic send_word(input req_t w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_bursts(input int n_words);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_words) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      for (int k = 0; k < burst && sent < n_words; k++) begin
        send_word(random_add());
        sent++;
      end
      burst = $urandom_range(1, 3);
      for (int k = 0; k < burst && sent < n_words; k++) begin
        send_word(select_word());
        sent++;
      end
    end
  endtask

  // sender goes quiet until every expected response has come back
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stim
    logic [15:0] pc;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    send_gap_pct = 26;
    stall_pct    = 66;
    sticky_left  = 8;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // select on an empty table
    send_word(select_word());
    // two finished entries, both removed by one select, leaving it empty
    send_word(add_word(8'hff, 8'hff, 16'hffff, 16'hffff));
    send_word(add_word(8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(select_word());
    // equal priorities: the older finished one goes first, then the next
    send_word(add_word(8'h11, 8'h80, 16'h5555, 16'h5555));
    send_word(add_word(8'h22, 8'h80, 16'haaaa, 16'haaaa));
    send_word(add_word(8'h33, 8'h00, 16'hffff, 16'h0000));
    send_word(add_word(8'h44, 8'h00, 16'h0000, 16'hffff));
    send_word(select_word());
    // a live pick stays in the table
    send_word(select_word());
    // fill to the top, then one add too many
    for (int i = 0; i < 14; i++) begin
      pc = 16'($urandom);
      send_word(add_word(8'($urandom), 8'($urandom_range(1, 255)), pc, pc));
    end
    send_word(add_word(8'h5a, 8'h01, 16'h0001, 16'h0002));
    send_word(select_word());
    drain();

    run_bursts(641);
    drain();
    send_gap_pct = 66;
    stall_pct    = 26;
    run_bursts(641);
    drain();
    send_gap_pct = 0;
    stall_pct    = 0;
    run_bursts(641);

    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
